>>> sv/bsfr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the byte-stuffed frame receiver.
// No dependencies.
package bsfr_pkg;

   localparam int unsigned LenWidth   = 24;
   localparam int unsigned CountWidth = LenWidth + 1;

   localparam logic [7:0] FlagByte   = 8'h7E;
   localparam logic [7:0] EscByte    = 8'h7D;
   localparam logic [7:0] EscFlagSeq = 8'h5E;
   localparam logic [7:0] EscEscSeq  = 8'h5D;

   localparam logic [LenWidth-1:0] MaxLenReset = LenWidth'(1024 * 1024 * 10);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
      logic       aborted;
      logic       corrupted;
   } rsp_item_type;

endpackage

>>> sv/bsfr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the receiver's input and result items.
// Depends on nothing.
interface bsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;
   logic       aborted;
   logic       corrupted;

   modport source (output valid, output data_byte, output has_byte, output last,
                   output aborted, output corrupted, input ready);
   modport sink (input valid, input data_byte, input has_byte, input last,
                 input aborted, input corrupted, output ready);
endinterface

>>> sv/bsfr_decode.sv
`timescale 1ns / 1ps
// Per-item de-stuffing, frame state and one-byte hold.
// Depends on bsfr_pkg.
module bsfr_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     rx_byte,
   input  logic [bsfr_pkg::LenWidth-1:0]  max_len,
   output logic                           push,
   output bsfr_pkg::rsp_item_type         result
);

   logic [7:0]                        held_byte_ff, held_byte_in;
   logic                              held_valid_ff, held_valid_in;
   logic                              esc_pend_ff, esc_pend_in;
   logic [bsfr_pkg::CountWidth-1:0]   raw_count_ff, raw_count_in;
   logic                              corrupt_ff, corrupt_in;

   logic [bsfr_pkg::CountWidth-1:0]   count_inc;
   logic [7:0]                        decoded;
   logic                              have_decoded;

   assign count_inc = raw_count_ff + bsfr_pkg::CountWidth'(1);

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      esc_pend_in   = esc_pend_ff;
      raw_count_in  = raw_count_ff;
      corrupt_in    = corrupt_ff;
      push          = 1'b0;
      result        = '0;
      decoded       = rx_byte;
      have_decoded  = 1'b0;

      if (accept) begin
         if (rx_byte == bsfr_pkg::FlagByte) begin
            if (raw_count_ff != '0) begin
               push             = 1'b1;
               result.data_byte = held_valid_ff ? held_byte_ff : 8'h00;
               result.has_byte  = held_valid_ff;
               result.last      = 1'b1;
               result.corrupted = corrupt_ff;
               held_valid_in    = 1'b0;
               esc_pend_in      = 1'b0;
               raw_count_in     = '0;
               corrupt_in       = 1'b0;
            end
         end else if (count_inc > {1'b0, max_len}) begin
            push           = 1'b1;
            result.last    = 1'b1;
            result.aborted = 1'b1;
            held_valid_in  = 1'b0;
            esc_pend_in    = 1'b0;
            raw_count_in   = '0;
            corrupt_in     = 1'b0;
         end else begin
            raw_count_in = count_inc;
            if (esc_pend_ff) begin
               esc_pend_in = 1'b0;
               case (rx_byte)
                  bsfr_pkg::EscFlagSeq: begin
                     decoded      = bsfr_pkg::FlagByte;
                     have_decoded = 1'b1;
                  end
                  bsfr_pkg::EscEscSeq: begin
                     decoded      = bsfr_pkg::EscByte;
                     have_decoded = 1'b1;
                  end
                  default: corrupt_in = 1'b1;
               endcase
            end else if (rx_byte == bsfr_pkg::EscByte) begin
               esc_pend_in = 1'b1;
            end else begin
               have_decoded = 1'b1;
            end

            if (have_decoded) begin
               if (held_valid_ff) begin
                  push             = 1'b1;
                  result.data_byte = held_byte_ff;
                  result.has_byte  = 1'b1;
               end
               held_byte_in  = decoded;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      if (reset) begin
         held_valid_ff <= 1'b0;
         esc_pend_ff   <= 1'b0;
         raw_count_ff  <= '0;
         corrupt_ff    <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         esc_pend_ff   <= esc_pend_in;
         raw_count_ff  <= raw_count_in;
         corrupt_ff    <= corrupt_in;
      end
   end

endmodule

>>> sv/bsfr_out_buf.sv
`timescale 1ns / 1ps
// Result register with a skid entry; ready toward the decoder is registered.
// Depends on bsfr_pkg.
module bsfr_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bsfr_pkg::rsp_item_type  push_item,
   output logic                    push_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bsfr_pkg::rsp_item_type  out_item
);

   bsfr_pkg::rsp_item_type main_ff, main_in;
   bsfr_pkg::rsp_item_type skid_ff, skid_in;
   logic                   main_vld_ff, main_vld_in;
   logic                   skid_vld_ff, skid_vld_in;
   logic                   pop;

   assign pop        = main_vld_ff & out_ready;
   assign push_ready = ~skid_vld_ff;
   assign out_valid  = main_vld_ff;
   assign out_item   = main_ff;

   always_comb begin
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!main_vld_ff || pop) begin
            main_in     = push_item;
            main_vld_in = 1'b1;
         end else begin
            skid_in     = push_item;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         main_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

endmodule

>>> sv/byte_stuffed_frame_receiver_core.sv
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame receiver.
// Depends on bsfr_pkg, bsfr_if, bsfr_decode and bsfr_out_buf.

// Takes one raw byte per item and removes HDLC-style byte stuffing: 0x7E
// delimits frames, 0x7D 0x5E gives 0x7E, 0x7D 0x5D gives 0x7D, and any other
// escaped byte is dropped and flags the frame corrupted. Each decoded byte is
// held until the next one arrives, so the closing flag delivers the final
// byte with last set; a frame that decodes to nothing yields a bare last
// item. A frame longer than csr_write_data bytes (raw, escapes counted) ends
// in a last+aborted item and collection restarts. An item is taken every
// cycle: decode and state update finish in the accept cycle and the result
// lands in a two-entry output register, so req_bus.ready falls only after
// two results are waiting on a stalled rsp_bus. The length register resets
// to 10485760; user must write it only while the block is idle (unenforced).
module byte_stuffed_frame_receiver_core (
   input  logic                          clock,
   input  logic                          reset,
   bsfr_req_if.sink                      req_bus,
   bsfr_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [bsfr_pkg::LenWidth-1:0] csr_write_data
);

   logic [bsfr_pkg::LenWidth-1:0] max_len_ff;
   logic                          accept;
   logic                          push;
   logic                          push_ready;
   bsfr_pkg::rsp_item_type        push_item;
   bsfr_pkg::rsp_item_type        out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= bsfr_pkg::MaxLenReset;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid & push_ready;

   bsfr_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_bus.rx_byte),
      .max_len (max_len_ff),
      .push    (push),
      .result  (push_item)
   );

   bsfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_item   (out_item)
   );

   assign rsp_bus.data_byte = out_item.data_byte;
   assign rsp_bus.has_byte  = out_item.has_byte;
   assign rsp_bus.last      = out_item.last;
   assign rsp_bus.aborted   = out_item.aborted;
   assign rsp_bus.corrupted = out_item.corrupted;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result pending right after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("input stalled with no result waiting");

   a_abort_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.aborted |->
         rsp_bus.last && !rsp_bus.has_byte && !rsp_bus.corrupted)
      else $error("malformed abort item");

   a_corrupt_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.corrupted |-> rsp_bus.last)
      else $error("corrupted flag outside frame end");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for byte_stuffed_frame_receiver_core: directed and random byte streams.
// Depends on bsfr_pkg, bsfr_if and the receiver RTL.
module tb;

   localparam int CycleLimit = 300000;

   class frame_scoreboard;
      logic [bsfr_pkg::LenWidth-1:0]   max_len;
      logic [7:0]                      held_byte;
      bit                              held_valid;
      bit                              esc_pending;
      bit                              frame_bad;
      logic [bsfr_pkg::CountWidth-1:0] raw_count;
      bsfr_pkg::rsp_item_type          expected_q[$];
      int                              errors;

      function new();
         max_len = bsfr_pkg::MaxLenReset;
         errors  = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         held_byte   = 8'h00;
         held_valid  = 1'b0;
         esc_pending = 1'b0;
         raw_count   = '0;
         frame_bad   = 1'b0;
      endfunction

      function void push(logic [7:0] data, bit has, bit lst, bit abrt, bit bad);
         bsfr_pkg::rsp_item_type r;
         r.data_byte = data;
         r.has_byte  = has;
         r.last      = lst;
         r.aborted   = abrt;
         r.corrupted = bad;
         expected_q.push_back(r);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // accepted input byte
      function void note_byte(logic [7:0] b);
         logic [7:0] decoded;
         bit         have_decoded;
         have_decoded = 1'b0;
         decoded      = 8'h00;
         if (b == bsfr_pkg::FlagByte) begin
            if (raw_count != 0) begin
               if (held_valid)
                  push(held_byte, 1'b1, 1'b1, 1'b0, frame_bad);
               else
                  push(8'h00, 1'b0, 1'b1, 1'b0, frame_bad);
               clear_frame();
            end
            return;
         end
         raw_count = raw_count + 1'b1;
         if (raw_count > {1'b0, max_len}) begin
            push(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            clear_frame();
            return;
         end
         if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == bsfr_pkg::EscFlagSeq) begin
               decoded      = bsfr_pkg::FlagByte;
               have_decoded = 1'b1;
            end else if (b == bsfr_pkg::EscEscSeq) begin
               decoded      = bsfr_pkg::EscByte;
               have_decoded = 1'b1;
            end else begin
               frame_bad = 1'b1;
            end
         end else if (b == bsfr_pkg::EscByte) begin
            esc_pending = 1'b1;
         end else begin
            decoded      = b;
            have_decoded = 1'b1;
         end
         if (!have_decoded)
            return;
         if (held_valid)
            push(held_byte, 1'b1, 1'b0, 1'b0, 1'b0);
         held_byte  = decoded;
         held_valid = 1'b1;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(bsfr_pkg::rsp_item_type got);
         bsfr_pkg::rsp_item_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
         if (got.has_byte !== want.has_byte)
            report($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
         if (got.aborted !== want.aborted)
            report($sformatf("aborted %b, want %b", got.aborted, want.aborted));
         if (got.corrupted !== want.corrupted)
            report($sformatf("corrupted %b, want %b", got.corrupted, want.corrupted));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [bsfr_pkg::LenWidth-1:0] csr_write_data;
   bit                            gaps_on;
   int                            stall_left;
   int                            cycles;
   int                            n_sent;
   frame_scoreboard               sb;

   bsfr_req_if req_bus ();
   bsfr_rsp_if rsp_bus ();

   byte_stuffed_frame_receiver_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_byte(req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(bsfr_pkg::rsp_item_type'{data_byte: rsp_bus.data_byte,
                                                     has_byte:  rsp_bus.has_byte,
                                                     last:      rsp_bus.last,
                                                     aborted:   rsp_bus.aborted,
                                                     corrupted: rsp_bus.corrupted});
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task send_byte(input logic [7:0] b);
      int gap;
      if (gaps_on && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      n_sent++;
      @(negedge clock);
   endtask

   task write_max_len(input logic [bsfr_pkg::LenWidth-1:0] v);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.max_len = v;
   endtask

   // mostly well-formed frames, some raw noise
   task send_random(input int n);
      int         stop_at;
      int         len;
      int         k;
      logic [7:0] b;
      stop_at = n_sent + n;
      while (n_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            send_byte(bsfr_pkg::FlagByte);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
               k = $urandom_range(0, 15);
               if (k == 0) begin
                  send_byte(bsfr_pkg::EscByte);
                  send_byte(bsfr_pkg::EscFlagSeq);
               end else if (k == 1) begin
                  send_byte(bsfr_pkg::EscByte);
                  send_byte(bsfr_pkg::EscEscSeq);
               end else if (k == 2) begin
                  send_byte(bsfr_pkg::EscByte);
                  send_byte(8'($urandom_range(0, 255)));
               end else begin
                  b = 8'($urandom_range(0, 255));
                  if (b == bsfr_pkg::FlagByte || b == bsfr_pkg::EscByte)
                     b = b ^ 8'h01;
                  send_byte(b);
               end
            end
            if ($urandom_range(0, 19) == 0)
               send_byte(bsfr_pkg::EscByte);
            send_byte(bsfr_pkg::FlagByte);
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = 8'h00;
      rsp_bus.ready    = 1'b0;
      gaps_on          = 1'b1;
      stall_left       = 0;
      cycles           = 0;
      n_sent           = 0;
      sb               = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty flag, data extremes, both escapes, bad escape,
      // frames that decode to nothing, trailing escape
      send_byte(bsfr_pkg::FlagByte);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(bsfr_pkg::EscByte);
      send_byte(bsfr_pkg::EscFlagSeq);
      send_byte(bsfr_pkg::EscByte);
      send_byte(bsfr_pkg::EscEscSeq);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(8'h41);
      send_byte(bsfr_pkg::EscByte);
      send_byte(8'h33);
      send_byte(8'h42);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(bsfr_pkg::EscByte);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(bsfr_pkg::EscByte);
      send_byte(8'h22);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(8'h55);
      send_byte(bsfr_pkg::EscByte);
      send_byte(bsfr_pkg::FlagByte);
      send_random(130);

      // limit of one byte: second raw byte aborts
      write_max_len(bsfr_pkg::LenWidth'(1));
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(bsfr_pkg::FlagByte);
      send_byte(bsfr_pkg::EscByte);
      send_byte(bsfr_pkg::FlagByte);
      send_random(50);

      write_max_len({bsfr_pkg::LenWidth{1'b1}});
      send_random(120);

      for (int p = 0; p < 4; p++) begin
         write_max_len(bsfr_pkg::LenWidth'($urandom_range(2, 24)));
         send_random(50);
      end

      write_max_len(bsfr_pkg::LenWidth'($urandom_range(3, 16)));
      gaps_on = 1'b0;
      send_random(100);

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
